// File: rtl/assert_macros.svh
// Assertion helpers shared by the allocator modules.
// Both expect a signal named clk in the calling scope; SADR_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SADR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SADR_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sadr_pkg.sv
package sadr_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int MAX_BATCH   = 64;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W       = 7;
  localparam int CMD_W       = 2;
  localparam int STS_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_SHORT    = 2'd1,
    STS_NOT_USED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_GRANT,
    ST_SINGLE
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;
    logic plan;
    logic grant;
    logic single;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_valid;
    logic multi;
    logic last_grant;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/slot_allocator_deferred_reclaim_top.sv
// Channel | Dir | Signals                          | Contents (lowest bit first)
// in      | in  | in_tvalid/tready/tdata/tuser     | tdata: count[6:0], rel_slot[12:7]; tuser: command
// out     | out | out_tvalid/tready/tdata/tuser/tlast | tdata: granted_slot[5:0], reclaimed[12:6],
//         |     |                                  |   available[19:13]; tuser: status; tlast: last
// cfg     | in  | cfg_valid/ready/data             | data: refresh_threshold, always ready
//
// Steps: the transaction is captured while idle, planned in the planning state, then its results
//   go out one per cycle while the output is free; a release, a refresh or an empty acquire gives one.
// The grant scan is a 64-bit find-first over the open (then waiting) slot mask.
// Reset (rst_n low, synchronous) opens every slot and sets the threshold to 32.
// A stalled output holds the pending result and freezes the scan.
module slot_allocator_deferred_reclaim_top import sadr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // count, rel_slot
  input  logic [CMD_W-1:0]       in_tuser,   // command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // granted_slot, reclaimed, available
  output logic [STS_W-1:0]       out_tuser,  // status
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sadr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sadr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/sadr_ctrl.sv
`include "assert_macros.svh"

module sadr_ctrl import sadr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        priority if (!sts.req_valid) state_nxt = ST_IDLE;
        else if (sts.multi)          state_nxt = ST_GRANT;
        else                         state_nxt = ST_SINGLE;
      end
      ST_GRANT: begin
        if (sts.out_free && sts.last_grant) state_nxt = ST_IDLE;
      end
      ST_SINGLE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      ST_PLAN:   cmd.plan   = 1'b1;
      ST_GRANT:  cmd.grant  = sts.out_free;
      ST_SINGLE: cmd.single = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SADR_ASSERT(a_push_free, (cmd.grant || cmd.single) |-> sts.out_free, "push into full output")
  `SADR_ASSERT_NR(a_reset_idle, !rst_n |=> state_r == ST_IDLE, "not idle after reset")

endmodule

// File: rtl/sadr_dp.sv
`include "assert_macros.svh"

module sadr_dp import sadr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STS_W-1:0]       out_tuser,
  output logic                   out_tlast
);

  // request
  logic [CMD_W-1:0]      cmd_r;
  logic [CNT_W-1:0]      want_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CNT_W-1:0]      thr_r;

  // pool state
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_COUNT-1:0] flush_r, flush_nxt;
  logic [CNT_W-1:0]      open_r, open_nxt;
  logic [CNT_W-1:0]      fcnt_r, fcnt_nxt;

  // plan of the current command
  logic [CNT_W-1:0]      remain_r, remain_nxt;
  logic [CNT_W-1:0]      rec_r, rec_nxt;
  logic [CNT_W-1:0]      avail_r, avail_nxt;
  status_t               status_r, status_nxt;
  logic                  reclaim_r, reclaim_nxt;

  // output register
  logic                  out_vld_r;
  logic [SLOT_W-1:0]     o_slot_r;
  status_t               o_status_r;
  logic                  o_last_r;
  logic [CNT_W-1:0]      o_rec_r;
  logic [CNT_W-1:0]      o_avail_r;

  logic [CNT_W-1:0]      in_count;
  logic                  short0;
  logic [CNT_W-1:0]      acq_rec, pool, total;
  logic                  rel_ok, rel_rec;
  logic [SLOT_COUNT-1:0] open_mask, sel_mask;
  logic [SLOT_W-1:0]     pick;
  logic                  out_free, push;

  assign in_count  = in_tdata[CNT_W-1:0];
  assign cfg_ready = 1'b1;

  // Acquire: grants come from open slots first; reclaimed slots only when short.
  always_comb begin
    short0  = open_r < want_r;
    acq_rec = short0 ? fcnt_r : '0;
    pool    = open_r + acq_rec;
    total   = (want_r < pool) ? want_r : pool;
    rel_ok  = (CNT_W'(slot_r) < CNT_W'(SLOT_COUNT)) && used_r[slot_r];
    rel_rec = open_r < thr_r;
  end

  // Scan open slots; once they run out, the waiting slots are the next in line.
  always_comb begin
    open_mask = ~(used_r | flush_r);
    sel_mask  = (|open_mask) ? open_mask : flush_r;
    pick      = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (sel_mask[i]) pick = SLOT_W'(i);
    end
  end

  assign out_free = !out_vld_r || out_tready;
  assign push     = cmd.grant || cmd.single;

  always_comb begin
    sts.req_valid  = (cmd_r == CMD_ACQUIRE) || (cmd_r == CMD_RELEASE) ||
                     (cmd_r == CMD_REFRESH);
    sts.multi      = (cmd_r == CMD_ACQUIRE) && (total != '0);
    sts.last_grant = remain_r == CNT_W'(1);
    sts.out_free   = out_free;
  end

  always_comb begin
    used_nxt    = used_r;
    flush_nxt   = flush_r;
    open_nxt    = open_r;
    fcnt_nxt    = fcnt_r;
    remain_nxt  = remain_r;
    rec_nxt     = rec_r;
    avail_nxt   = avail_r;
    status_nxt  = status_r;
    reclaim_nxt = reclaim_r;
    if (cmd.plan) begin
      unique case (cmd_r)
        CMD_ACQUIRE: begin
          remain_nxt  = total;
          rec_nxt     = acq_rec;
          avail_nxt   = pool - total;
          open_nxt    = pool - total;
          status_nxt  = (total < want_r) ? STS_SHORT : STS_OK;
          reclaim_nxt = short0;
          if (short0) fcnt_nxt = '0;
        end
        CMD_RELEASE: begin
          rec_nxt    = '0;
          avail_nxt  = open_r;
          status_nxt = STS_OK;
          if (rel_ok) begin
            used_nxt[slot_r] = 1'b0;
            if (rel_rec) begin
              flush_nxt = '0;
              rec_nxt   = fcnt_r + CNT_W'(1);
              open_nxt  = open_r + fcnt_r + CNT_W'(1);
              avail_nxt = open_r + fcnt_r + CNT_W'(1);
              fcnt_nxt  = '0;
            end else begin
              flush_nxt[slot_r] = 1'b1;
              fcnt_nxt          = fcnt_r + CNT_W'(1);
            end
          end else begin
            status_nxt = STS_NOT_USED;
          end
        end
        CMD_REFRESH: begin
          flush_nxt  = '0;
          rec_nxt    = fcnt_r;
          open_nxt   = open_r + fcnt_r;
          avail_nxt  = open_r + fcnt_r;
          fcnt_nxt   = '0;
          status_nxt = STS_OK;
        end
        default: ;
      endcase
    end
    if (cmd.grant) begin
      used_nxt[pick]  = 1'b1;
      flush_nxt[pick] = 1'b0;
      remain_nxt      = remain_r - CNT_W'(1);
      // drop whatever waiting slots the reclaim freed but the batch left
      if (remain_r == CNT_W'(1) && reclaim_r) flush_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      flush_r   <= '0;
      open_r    <= CNT_W'(SLOT_COUNT);
      fcnt_r    <= '0;
      thr_r     <= THR_RESET;
      remain_r  <= '0;
      reclaim_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      flush_r   <= flush_nxt;
      open_r    <= open_nxt;
      fcnt_r    <= fcnt_nxt;
      remain_r  <= remain_nxt;
      reclaim_r <= reclaim_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_data;
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r  <= in_tuser;
      want_r <= (in_count > CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH) : in_count;
      slot_r <= in_tdata[CNT_W +: SLOT_W];
    end
    rec_r    <= rec_nxt;
    avail_r  <= avail_nxt;
    status_r <= status_nxt;
    if (push) begin
      o_slot_r   <= cmd.grant ? pick : '0;
      o_last_r   <= cmd.grant ? (remain_r == CNT_W'(1)) : 1'b1;
      o_status_r <= status_r;
      o_rec_r    <= rec_r;
      o_avail_r  <= avail_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {(OUT_TDATA_W - 2 * CNT_W - SLOT_W)'(0), o_avail_r, o_rec_r, o_slot_r};

  `SADR_ASSERT(a_pool_bound, (CNT_W+1)'(open_r) + (CNT_W+1)'(fcnt_r) <= (CNT_W+1)'(SLOT_COUNT), "open plus waiting exceeds pool")
  `SADR_ASSERT(a_disjoint, (used_r & flush_r) == '0, "slot both used and waiting")
  `SADR_ASSERT(a_grant_has_slot, cmd.grant |-> (sel_mask != '0), "grant with no candidate slot")

endmodule
